// File: design/ale_pkg.sv
// ---------------------------------------------------------------------------
// ale_pkg - shared types and constants of the assembly line encoder
// Character codes, parser phases, command words between the parser and the
// result sequencer, and the mnemonic and operand-layout tables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ale_pkg;

    // result kinds on the output tuser
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // input function codes
    localparam logic FUNC_CHAR = 1'b0;

    // character codes
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_TICK   = 8'h27;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_D  = 8'h64;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    localparam logic [15:0] REG_MAX = 16'd31;
    localparam logic [6:0]  OP_NOP  = 7'd64;

    // command queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_START,
        PH_STR,
        PH_STR_DONE,
        PH_MN1,
        PH_MN2,
        PH_SKIP,
        PH_FIELDS
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_NONE,
        ROLE_REG,
        ROLE_IMM
    } role_t;

    typedef enum logic [1:0] {
        IM_REG,
        IM_DEC,
        IM_BIN,
        IM_CHAR
    } imode_t;

    typedef enum logic [2:0] {
        OPT_NONE,
        OPT_RI16,
        OPT_RRI8,
        OPT_RRR,
        OPT_II8
    } optype_t;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_ERR,
        TAIL_DONE
    } tail_t;

    // one command word: data bytes first, then an optional error or done
    typedef struct packed {
        logic [2:0]      ndata;
        logic [3:0][7:0] bytes;
        tail_t           tail;
    } cmd_t;

    typedef struct packed {
        logic            err;
        logic [2:0][7:0] ob;
    } close_t;

    function automatic optype_t op_type(input logic [6:0] op);
        optype_t t;
        if (op == 7'd1) begin
            t = OPT_RI16;
        end else if (op inside {[7'd2:7'd7], [7'd16:7'd20]}) begin
            t = OPT_RRI8;
        end else if (op inside {[7'd8:7'd15]}) begin
            t = OPT_RRR;
        end else if (op == 7'd21) begin
            t = OPT_II8;
        end else begin
            t = OPT_NONE;
        end
        return t;
    endfunction

    function automatic role_t field_role(input logic [6:0] op, input logic [1:0] idx);
        role_t r;
        case (op_type(op))
            OPT_RI16: r = (idx == 2'd0) ? ROLE_REG : ((idx == 2'd1) ? ROLE_IMM : ROLE_NONE);
            OPT_RRI8: r = (idx < 2'd2) ? ROLE_REG : ROLE_IMM;
            OPT_RRR:  r = ROLE_REG;
            OPT_II8:  r = (idx < 2'd2) ? ROLE_IMM : ROLE_NONE;
            default:  r = ROLE_NONE;
        endcase
        return r;
    endfunction

    // mnemonic lookup: bit 7 set when known, low bits the opcode
    function automatic logic [7:0] classify(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
        logic [7:0] r;
        case ({a, b, c})
            "hlt":   r = {1'b1, 7'd0};
            "lim":   r = {1'b1, 7'd1};
            "l08":   r = {1'b1, 7'd2};
            "l16":   r = {1'b1, 7'd3};
            "l32":   r = {1'b1, 7'd4};
            "s08":   r = {1'b1, 7'd5};
            "s16":   r = {1'b1, 7'd6};
            "s32":   r = {1'b1, 7'd7};
            "and":   r = {1'b1, 7'd8};
            "eth":   r = {1'b1, 7'd9};
            "xor":   r = {1'b1, 7'd10};
            "nor":   r = {1'b1, 7'd11};
            "add":   r = {1'b1, 7'd12};
            "adc":   r = {1'b1, 7'd13};
            "shl":   r = {1'b1, 7'd14};
            "shr":   r = {1'b1, 7'd15};
            "jal":   r = {1'b1, 7'd16};
            "beq":   r = {1'b1, 7'd17};
            "bne":   r = {1'b1, 7'd18};
            "blt":   r = {1'b1, 7'd19};
            "bgt":   r = {1'b1, 7'd20};
            "int":   r = {1'b1, 7'd21};
            "nop":   r = {1'b1, OP_NOP};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/ale_front.sv
// ---------------------------------------------------------------------------
// ale_front - character parser
// Takes one character word a cycle while the queue has room, tracks the line
// state and pushes one command word for every input that produces results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ale_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // ch
    input  wire logic          s_tuser,   // func
    input  wire logic          q_full,
    output logic               push,
    output ale_pkg::cmd_t      push_cmd
);
    import ale_pkg::*;

    logic            halted_reg, halted_next;
    phase_t          phase_reg, phase_next;
    logic [15:0]     mn_reg, mn_next;
    logic [6:0]      op_reg, op_next;
    logic [1:0]      fnum_reg, fnum_next;
    logic [1:0]      foff_reg, foff_next;
    imode_t          imode_reg, imode_next;
    logic [15:0]     acc_reg, acc_next;
    logic            neg_reg, neg_next;
    logic            lerr_reg, lerr_next;
    logic [2:0][7:0] ob_reg, ob_next;
    logic            esc_reg, esc_next;

    logic            fire;
    logic            do_finish;

    function automatic close_t close_field(input logic [6:0] op, input logic [1:0] idx,
                                           input logic [1:0] foff, input logic neg,
                                           input logic [15:0] acc,
                                           input logic [2:0][7:0] ob);
        close_t      r;
        role_t       role;
        logic [15:0] v;
        r.err = 1'b0;
        r.ob  = ob;
        role  = field_role(op, idx);
        v     = neg ? 16'(16'd0 - acc) : acc;
        if (role != ROLE_NONE && idx != 2'd3) begin
            if (foff == 2'd0 || foff == 2'd3) begin
                r.err = 1'b1;
            end else if (role == ROLE_REG) begin
                if (v > REG_MAX) r.err = 1'b1;
                else r.ob[idx] = v[7:0];
            end else if (op_type(op) == OPT_RI16) begin
                r.ob[1] = v[7:0];
                r.ob[2] = v[15:8];
            end else begin
                r.ob[idx] = v[7:0];
            end
        end
        return r;
    endfunction

    assign s_tready  = !q_full;
    assign fire      = s_tvalid && s_tready && !halted_reg;
    assign do_finish = fire && (s_tuser != FUNC_CHAR || s_tdata == CH_LF);

    // parser state update
    always_comb begin
        close_t     cf;
        role_t      role_v;
        logic       lerr_v;
        logic       err_v;
        logic [7:0] cls;

        halted_next = halted_reg;
        phase_next  = phase_reg;
        mn_next     = mn_reg;
        op_next     = op_reg;
        fnum_next   = fnum_reg;
        foff_next   = foff_reg;
        imode_next  = imode_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        lerr_next   = lerr_reg;
        ob_next     = ob_reg;
        esc_next    = esc_reg;
        push        = 1'b0;
        push_cmd    = '0;
        cf          = '0;
        role_v      = ROLE_NONE;
        lerr_v      = lerr_reg;
        err_v       = 1'b0;
        cls         = 8'd0;

        if (do_finish) begin
            // line end or end of input
            case (phase_reg)
                PH_START, PH_STR_DONE: begin
                end
                PH_SKIP, PH_FIELDS: begin
                    if (!lerr_v) begin
                        cf     = close_field(op_reg, fnum_reg, foff_reg, neg_reg,
                                             acc_reg, ob_reg);
                        lerr_v = cf.err;
                        for (int k = 1; k < 3; k++) begin
                            if (k > int'(fnum_reg) &&
                                field_role(op_reg, 2'(k)) != ROLE_NONE) begin
                                lerr_v = 1'b1;
                            end
                        end
                    end
                    if (lerr_v) begin
                        err_v = 1'b1;
                    end else begin
                        push_cmd.ndata = 3'd4;
                        push_cmd.bytes = {cf.ob[2], cf.ob[1], cf.ob[0], 1'b0, op_reg};
                    end
                end
                default: err_v = 1'b1;
            endcase
            phase_next = PH_START;
            mn_next    = '0;
            op_next    = '0;
            fnum_next  = '0;
            foff_next  = '0;
            imode_next = IM_REG;
            acc_next   = '0;
            neg_next   = 1'b0;
            lerr_next  = 1'b0;
            ob_next    = '0;
            esc_next   = 1'b0;
            if (err_v) begin
                halted_next   = 1'b1;
                push_cmd.tail = TAIL_ERR;
            end else if (s_tuser != FUNC_CHAR) begin
                halted_next   = 1'b1;
                push_cmd.tail = TAIL_DONE;
            end
        end else if (fire) begin
            // ordinary character
            case (phase_reg)
                PH_START: begin
                    if (s_tdata == CH_QUOTE) begin
                        phase_next = PH_STR;
                    end else begin
                        mn_next    = {8'd0, s_tdata};
                        phase_next = PH_MN1;
                    end
                end
                PH_STR: begin
                    if (esc_reg) begin
                        esc_next       = 1'b0;
                        push_cmd.ndata = 3'd1;
                        push_cmd.bytes[0] = (s_tdata == CH_ZERO) ? 8'd0 :
                                            ((s_tdata == CH_LOW_N) ? CH_LF : s_tdata);
                    end else if (s_tdata == CH_BSLASH) begin
                        esc_next = 1'b1;
                    end else if (s_tdata == CH_QUOTE) begin
                        phase_next = PH_STR_DONE;
                    end else begin
                        push_cmd.ndata    = 3'd1;
                        push_cmd.bytes[0] = s_tdata;
                    end
                end
                PH_MN1: begin
                    mn_next    = {s_tdata, mn_reg[7:0]};
                    phase_next = PH_MN2;
                end
                PH_MN2: begin
                    cls = classify(mn_reg[7:0], mn_reg[15:8], s_tdata);
                    if (cls[7]) op_next = cls[6:0];
                    else lerr_next = 1'b1;
                    phase_next = PH_SKIP;
                end
                PH_SKIP: begin
                    phase_next = PH_FIELDS;
                    fnum_next  = '0;
                    foff_next  = '0;
                end
                PH_FIELDS: begin
                    if (!lerr_reg) begin
                        role_v = field_role(op_reg, fnum_reg);
                        if (s_tdata == CH_SPACE && foff_reg != 2'd3) begin
                            // field separator
                            cf = close_field(op_reg, fnum_reg, foff_reg, neg_reg,
                                             acc_reg, ob_reg);
                            ob_next = cf.ob;
                            if (cf.err || fnum_reg >= 2'd2) begin
                                lerr_next = 1'b1;
                            end else begin
                                fnum_next = fnum_reg + 2'd1;
                                foff_next = 2'd3;
                            end
                        end else if (foff_reg == 2'd0 || foff_reg == 2'd3) begin
                            // field prefix
                            foff_next  = 2'd1;
                            acc_next   = '0;
                            neg_next   = 1'b0;
                            imode_next = IM_REG;
                            if (role_v == ROLE_REG) begin
                                if (s_tdata != CH_LOW_R) lerr_next = 1'b1;
                            end else if (role_v == ROLE_IMM) begin
                                if (s_tdata == CH_LOW_D) imode_next = IM_DEC;
                                else if (s_tdata == CH_LOW_B) imode_next = IM_BIN;
                                else if (s_tdata == CH_TICK) imode_next = IM_CHAR;
                                else lerr_next = 1'b1;
                            end
                        end else if (role_v == ROLE_NONE) begin
                            foff_next = 2'd2;
                        end else if (imode_reg == IM_CHAR) begin
                            if (foff_reg == 2'd1) begin
                                acc_next  = {8'd0, s_tdata};
                                foff_next = 2'd2;
                            end
                        end else if (imode_reg != IM_BIN && foff_reg == 2'd1 &&
                                     s_tdata == CH_MINUS) begin
                            neg_next  = 1'b1;
                            foff_next = 2'd2;
                        end else begin
                            // digit accumulation
                            foff_next = 2'd2;
                            if (imode_reg == IM_BIN) begin
                                if (s_tdata == CH_ZERO || s_tdata == CH_ONE)
                                    acc_next = {acc_reg[14:0], s_tdata[0]};
                                else lerr_next = 1'b1;
                            end else begin
                                if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE)
                                    acc_next = 16'({acc_reg, 3'd0} + {acc_reg, 1'b0}
                                                   + {8'd0, s_tdata - CH_ZERO});
                                else lerr_next = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        push = fire && (push_cmd.ndata != 3'd0 || push_cmd.tail != TAIL_NONE);
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_reg <= 1'b0;
            phase_reg  <= PH_START;
            mn_reg     <= '0;
            op_reg     <= '0;
            fnum_reg   <= '0;
            foff_reg   <= '0;
            imode_reg  <= IM_REG;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            lerr_reg   <= 1'b0;
            ob_reg     <= '0;
            esc_reg    <= 1'b0;
        end else begin
            halted_reg <= halted_next;
            phase_reg  <= phase_next;
            mn_reg     <= mn_next;
            op_reg     <= op_next;
            fnum_reg   <= fnum_next;
            foff_reg   <= foff_next;
            imode_reg  <= imode_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            lerr_reg   <= lerr_next;
            ob_reg     <= ob_next;
            esc_reg    <= esc_next;
        end
    end
endmodule
`default_nettype wire

// File: design/ale_cmd_fifo.sv
// ---------------------------------------------------------------------------
// ale_cmd_fifo - command queue
// Short queue of command words between the parser and the result sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ale_cmd_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire ale_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output ale_pkg::cmd_t      head
);
    import ale_pkg::*;

    cmd_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]  count_reg, count_next;

    assign full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule
`default_nettype wire

// File: design/ale_back.sv
// ---------------------------------------------------------------------------
// ale_back - result sequencer
// Expands the command word at the head of the queue into output words,
// one per cycle while m_tready is high; marks the last word of each command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ale_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          empty,
    input  wire ale_pkg::cmd_t head,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,   // out_byte
    output logic [1:0]         m_tuser,   // kind
    output logic               m_tlast    // last_in_run
);
    import ale_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic [2:0] total;
    logic       fire;

    assign m_tvalid = !empty;
    assign fire     = m_tvalid && m_tready;
    assign total    = head.ndata + 3'((head.tail != TAIL_NONE) ? 1 : 0);
    assign m_tlast  = (idx_reg == total - 3'd1);
    assign pop      = fire && m_tlast;

    // word select
    always_comb begin
        m_tdata = 8'd0;
        if (idx_reg < head.ndata) begin
            m_tdata = head.bytes[idx_reg[1:0]];
            m_tuser = KIND_DATA;
        end else begin
            case (head.tail)
                TAIL_ERR:  m_tuser = KIND_ERR;
                TAIL_DONE: m_tuser = KIND_DONE;
                default:   m_tuser = KIND_DATA;
            endcase
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (pop) idx_next = 3'd0;
        else if (fire) idx_next = idx_reg + 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 3'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end
endmodule
`default_nettype wire

// File: design/asm_line_encoder_unit.sv
// ---------------------------------------------------------------------------
// asm_line_encoder_unit - assembly text to machine byte encoder
// Parses text one character a word and emits string bytes, four-byte
// instructions, an error word or a done word.
// ---------------------------------------------------------------------------
// channel  dir  tdata          tuser        tlast
// s_       in   ch [7:0]       func         -
// m_       out  out_byte [7:0] kind [1:0]   last_in_run
//
// One character word is taken each cycle while the command queue has room.
// The sequencer sends one output word per cycle while m_tready is high; a
// completed instruction gives four output words, then done at end of input.
// The four-entry command queue lets the parser run ahead during those bursts.
// Reset is synchronous and active low; it clears the parser and the queue.
// Output stalls back up through the queue to s_tready only when it is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module asm_line_encoder_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // ch
    input  wire logic       s_tuser,   // func
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic [1:0]      m_tuser,   // kind
    output logic            m_tlast    // last_in_run
);
    import ale_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    cmd_t push_cmd;
    cmd_t head;

    // parser
    ale_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // command queue
    ale_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    // result sequencer
    ale_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire
